// File: rtl/ifsf_pkg.sv
package ifsf_pkg;

  localparam logic [7:0] FLAG_OCTET = 8'h7E;
  localparam logic [7:0] ESC_OCTET  = 8'h7D;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  // One classified payload byte, handed from front to back
  typedef struct packed {
    logic       hdr;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       last;
    logic [7:0] check;
  } job_t;

  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == FLAG_OCTET) || (b == ESC_OCTET);
  endfunction

  function automatic logic [7:0] escaped(input logic [7:0] b);
    escaped = (b == FLAG_OCTET) ? ESC_FLAG : ESC_ESC;
  endfunction

endpackage

// File: rtl/info_frame_stuffing_framer_core.sv
// Information-frame framer: takes payload bytes and emits a flag-delimited,
// byte-stuffed line stream, one line byte per cycle while out_stall is low. The
// first byte of a frame brings four header bytes (flag, address, control,
// header check); each payload byte gives one or two line bytes; the last byte
// of a frame adds one or two check bytes and the closing flag. So one input
// transfer produces 1 to 9 output transfers, and the output port, at one byte
// per cycle unless out_stall holds it, sets the sustained rate. Input
// transfers are taken every cycle while the two-entry job queue between the
// front classifier and the back sequencer has room. address_byte
// (cfg_write/cfg_data) applies from the next frame header.
module info_frame_stuffing_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       retransmit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       run_last
);

  ifsf_pkg::job_t push_job;
  ifsf_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           head_valid;

  assign in_stall = q_full;

  ifsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .retransmit (retransmit),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  ifsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ifsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

`ifndef SYNTH
  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == ifsf_pkg::FLAG_OCTET && run_last)
    else $error("closing flag malformed");

  a_esc_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte == ifsf_pkg::ESC_OCTET |-> !run_last && !frame_end)
    else $error("escape byte ends an item");

  a_open_flag_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte == ifsf_pkg::FLAG_OCTET && !frame_end |-> !run_last)
    else $error("opening flag ends an item");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full && in_valid)
    else $error("push into full queue");
`endif

endmodule

// File: rtl/ifsf_front.sv
module ifsf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_data,
  input  logic           in_valid,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  input  logic           retransmit,
  input  logic           q_full,
  output logic           push,
  output ifsf_pkg::job_t job
);

  logic [7:0] address_byte;
  logic       in_frame;
  logic       next_sequence;
  logic       frame_sequence;
  logic [7:0] running_check;

  logic       seq;
  logic [7:0] check_next;

  assign push = in_valid && !q_full;

  // retransmit only matters on the first byte of a frame
  assign seq        = (in_frame || retransmit) ? frame_sequence : next_sequence;
  assign check_next = (in_frame ? running_check : 8'h00) ^ data_byte;

  always_comb begin
    job.hdr   = !in_frame;
    job.addr  = address_byte;
    job.ctrl  = seq ? ifsf_pkg::CTRL_SEQ1 : ifsf_pkg::CTRL_SEQ0;
    job.data  = data_byte;
    job.last  = last_byte;
    job.check = check_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte   <= ifsf_pkg::ADDR_RESET;
      in_frame       <= 1'b0;
      next_sequence  <= 1'b0;
      frame_sequence <= 1'b0;
      running_check  <= 8'h00;
    end else begin
      if (cfg_write) begin
        address_byte <= cfg_data;
      end
      if (push) begin
        frame_sequence <= seq;
        if (last_byte) begin
          in_frame      <= 1'b0;
          running_check <= 8'h00;
          next_sequence <= !seq;
        end else begin
          in_frame      <= 1'b1;
          running_check <= check_next;
        end
      end
    end
  end

endmodule

// File: rtl/ifsf_queue.sv
module ifsf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ifsf_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output ifsf_pkg::job_t head
);

  ifsf_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ifsf_back.sv
module ifsf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ifsf_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           frame_end,
  output logic           run_last
);

  typedef enum logic [3:0] {
    P_START,
    P_FLAG_OPEN,
    P_ADDR,
    P_CTRL,
    P_HCHK,
    P_DATA,
    P_DATA_ESC,
    P_CHK,
    P_CHK_ESC,
    P_FLAG_CLOSE
  } phase_t;

  phase_t     phase;
  phase_t     cur;
  phase_t     phase_next;
  logic [7:0] byte_c;
  logic       end_c;
  logic       last_c;
  logic       load;

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && last_c;

  always_comb begin
    cur = phase;
    if (phase == P_START) begin
      if (head.hdr) begin
        cur = P_FLAG_OPEN;
      end else begin
        cur = P_DATA;
      end
    end
  end

  always_comb begin
    byte_c     = ifsf_pkg::FLAG_OCTET;
    end_c      = 1'b0;
    last_c     = 1'b0;
    phase_next = P_START;
    unique case (cur)
      P_FLAG_OPEN: begin
        phase_next = P_ADDR;
      end
      P_ADDR: begin
        byte_c     = head.addr;
        phase_next = P_CTRL;
      end
      P_CTRL: begin
        byte_c     = head.ctrl;
        phase_next = P_HCHK;
      end
      P_HCHK: begin
        byte_c     = head.addr ^ head.ctrl;
        phase_next = P_DATA;
      end
      P_START, P_DATA: begin
        if (ifsf_pkg::needs_escape(head.data)) begin
          byte_c     = ifsf_pkg::ESC_OCTET;
          phase_next = P_DATA_ESC;
        end else begin
          byte_c     = head.data;
          phase_next = P_CHK;
          last_c     = !head.last;
        end
      end
      P_DATA_ESC: begin
        byte_c     = ifsf_pkg::escaped(head.data);
        phase_next = P_CHK;
        last_c     = !head.last;
      end
      P_CHK: begin
        if (ifsf_pkg::needs_escape(head.check)) begin
          byte_c     = ifsf_pkg::ESC_OCTET;
          phase_next = P_CHK_ESC;
        end else begin
          byte_c     = head.check;
          phase_next = P_FLAG_CLOSE;
        end
      end
      P_CHK_ESC: begin
        byte_c     = ifsf_pkg::escaped(head.check);
        phase_next = P_FLAG_CLOSE;
      end
      P_FLAG_CLOSE: begin
        end_c  = 1'b1;
        last_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= P_START;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        phase <= last_c ? P_START : phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_c;
      frame_end <= end_c;
      run_last  <= last_c;
    end
  end

endmodule
